[rtl/m4t_pkg.sv]
package m4t_pkg;

  localparam int WORD_W      = 32;
  localparam int ACC_W       = 66;

  localparam logic [2:0] OP_WR_CUR = 3'd0;
  localparam logic [2:0] OP_WR_STG = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_TRN    = 3'd3;
  localparam logic [2:0] OP_XFM    = 3'd4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [3:0]  vec4_t;
  typedef word_t [15:0] mat_t;

  typedef enum logic [1:0] {
    KIND_MUL = 2'd0,
    KIND_TRN = 2'd1,
    KIND_XFM = 2'd2
  } kind_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [1:0] col;
  } tag_t;

  typedef struct packed {
    logic commit;
    logic col3_we;
  } upd_t;

endpackage

[rtl/m4t_lane.sv]
module m4t_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          en,
  input  m4t_pkg::vec4_t row,
  input  m4t_pkg::vec4_t vec,
  output m4t_pkg::word_t sum
);
  import m4t_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -66'sd2147483648;

  logic signed [2*WORD_W-1:0] prod_r [4];
  logic signed [ACC_W-1:0]    acc;
  word_t                      sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= $signed(row[k]) * $signed(vec[k]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc = acc + ACC_W'(prod_r[k] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc > SAT_MAX) begin
        sum_r <= SAT_MAX[WORD_W-1:0];
      end else if (acc < SAT_MIN) begin
        sum_r <= SAT_MIN[WORD_W-1:0];
      end else begin
        sum_r <= acc[WORD_W-1:0];
      end
    end
  end

  assign sum = sum_r;

endmodule

[rtl/m4t_ctrl.sv]
module m4t_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [2:0]    in_tuser,
  input  logic          out_tvalid,
  input  logic          out_tready,
  output logic          in_tready,
  output logic          en,
  output m4t_pkg::tag_t iss,
  output m4t_pkg::tag_t t2
);
  import m4t_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] col_r, col_nxt;
  tag_t       t1_r, t2_r;
  logic       fire;

  assign in_tready = (state_r == ST_IDLE);
  assign fire      = in_tvalid && in_tready;
  assign en        = !(t2_r.vld && t2_r.kind == KIND_XFM && out_tvalid && !out_tready);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    iss       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          unique case (in_tuser)
            OP_MUL: begin
              iss       = '{vld: 1'b1, kind: KIND_MUL, col: 2'd0};
              col_nxt   = 2'd1;
              state_nxt = ST_MUL;
            end
            OP_TRN: begin
              iss       = '{vld: 1'b1, kind: KIND_TRN, col: 2'd3};
              state_nxt = ST_WAIT;
            end
            OP_XFM: begin
              iss       = '{vld: 1'b1, kind: KIND_XFM, col: 2'd0};
              state_nxt = ST_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        iss     = '{vld: 1'b1, kind: KIND_MUL, col: col_r};
        col_nxt = col_r + 2'd1;
        if (col_r == 2'd3) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (t2_r.vld && en && (t2_r.kind != KIND_MUL || t2_r.col == 2'd3)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= 2'd0;
      t1_r    <= '0;
      t2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      if (en) begin
        t1_r <= iss;
        t2_r <= t1_r;
      end
    end
  end

  assign t2 = t2_r;

endmodule

[rtl/m4t_merge.sv]
module m4t_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  m4t_pkg::tag_t  t2,
  input  m4t_pkg::vec4_t sum,
  input  logic           out_tready,
  output logic           out_tvalid,
  output m4t_pkg::vec4_t out_data,
  output m4t_pkg::upd_t  upd,
  output m4t_pkg::mat_t  new_mat
);
  import m4t_pkg::*;

  vec4_t tmp_r [3];
  vec4_t data_r;
  logic  valid_r;
  logic  retire;

  assign retire      = t2.vld && en;
  assign upd.commit  = retire && t2.kind == KIND_MUL && t2.col == 2'd3;
  assign upd.col3_we = retire && t2.kind == KIND_TRN;

  always_ff @(posedge clk) begin
    if (retire && t2.kind == KIND_MUL && t2.col != 2'd3) begin
      tmp_r[t2.col] <= sum;
    end
    if (retire && t2.kind == KIND_XFM) begin
      data_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (retire && t2.kind == KIND_XFM) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 4; r++) begin
        new_mat[c*4+r] = tmp_r[c][r];
      end
    end
    for (int r = 0; r < 4; r++) begin
      new_mat[12+r] = sum[r];
    end
  end

  assign out_tvalid = valid_r;
  assign out_data   = data_r;

endmodule

[rtl/matrix4_transform_unit_top.sv]
// Transforms 4-vectors by a 4x4 column-major Q16.16 matrix held inside the block.
// The input channel carries one command per beat: the opcode in in_tuser and the
// element index, element value and x, y, z, w operands in in_tdata. Element writes
// go to the current or staging matrix; multiply replaces current by current times
// staging; translate post-multiplies current by a translation; transform returns
// the four saturated components of current times the vector on the output channel.
// Four dot-product lanes, one per matrix row, each with four multipliers and a
// registered adder, do all the arithmetic; a merge stage collects their results.
// An element write leaves the input ready. Transform and translate pass through the
// multiply stage, the sum stage and the write-back; a transform result appears on
// out_tvalid after its write-back. Multiply streams the four staging columns
// through the lanes. The output register holds a result until taken; a following
// transform stalls in the lanes while it is still full. Reset loads the identity
// into current and empties the pipeline; staging is undefined until written.
module matrix4_transform_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // elem_index, elem_value, x_in, y_in, z_in, w_in
  input  logic [167:0] in_tdata,
  // opcode
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // x_out, y_out, z_out, w_out
  output logic [127:0] out_tdata
);
  import m4t_pkg::*;

  localparam word_t FX_ONE = 32'sd1 <<< FRAC_BITS;

  word_t       cur_r [16];
  word_t       stg_r [16];
  logic        fire;
  logic        en;
  tag_t        iss, t2;
  upd_t        upd;
  mat_t        new_mat;
  vec4_t       vec, sum, out_data;
  vec4_t       row [4];
  logic [3:0]  elem_index;
  word_t       elem_value, x_in, y_in, z_in, w_in;

  assign elem_index = in_tdata[3:0];
  assign elem_value = in_tdata[35:4];
  assign x_in       = in_tdata[67:36];
  assign y_in       = in_tdata[99:68];
  assign z_in       = in_tdata[131:100];
  assign w_in       = in_tdata[163:132];
  assign fire       = in_tvalid && in_tready;

  m4t_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .en         (en),
    .iss        (iss),
    .t2         (t2)
  );

  always_comb begin
    case (iss.kind)
      KIND_MUL: begin
        for (int k = 0; k < 4; k++) begin
          vec[k] = stg_r[{iss.col, 2'(k)}];
        end
      end
      KIND_TRN: vec = {FX_ONE, z_in, y_in, x_in};
      default:  vec = {w_in, z_in, y_in, x_in};
    endcase
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    for (genvar k = 0; k < 4; k++) begin : g_row
      assign row[r][k] = cur_r[k*4+r];
    end
    m4t_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .en  (en),
      .row (row[r]),
      .vec (vec),
      .sum (sum[r])
    );
  end

  m4t_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .t2         (t2),
    .sum        (sum),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_data),
    .upd        (upd),
    .new_mat    (new_mat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        cur_r[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? FX_ONE : '0;
      end
    end else if (upd.commit) begin
      for (int i = 0; i < 16; i++) begin
        cur_r[i] <= new_mat[i];
      end
    end else if (upd.col3_we) begin
      for (int i = 12; i < 16; i++) begin
        cur_r[i] <= new_mat[i];
      end
    end else if (fire && in_tuser == OP_WR_CUR) begin
      cur_r[elem_index] <= elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_tuser == OP_WR_STG) begin
      stg_r[elem_index] <= elem_value;
    end
  end

  assign out_tdata = out_data;

endmodule

[rtl/m4t_chk.sv]
module m4t_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [2:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);
  import m4t_pkg::*;

  logic fire;
  assign fire = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed or dropped");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_tuser == OP_WR_CUR || in_tuser == OP_WR_STG) |=> in_tready)
    else $error("element write did not complete in one cycle");

  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_tuser == OP_MUL |-> ##5 !in_tready)
    else $error("multiply released the input before its last column");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(fire && in_tuser == OP_XFM, 3))
    else $error("result appeared without a transform three cycles earlier");

endmodule

bind matrix4_transform_unit_top m4t_chk u_chk (.*);

[sim/matrix4_transform_unit_top_tb.sv]
`timescale 1ns / 1ps

module matrix4_transform_unit_top_tb;
  import m4t_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam word_t FX_ONE = 32'sh0001_0000;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [2:0]   in_tuser = OP_WR_CUR;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  word_t current_mat[16];
  word_t staging_mat[16];
  vec4_t xfm_expected[$];

  matrix4_transform_unit_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint fx_mul(input word_t a, input word_t b);
    longint prod;
    prod = longint'(a) * longint'(b);
    return prod >>> FRAC_BITS;
  endfunction

  function automatic word_t sat_word(input longint acc);
    if (acc > longint'(WORD_MAX)) return WORD_MAX;
    if (acc < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(acc);
  endfunction

  function automatic void update_matrix_state(input logic [2:0] op, input logic [3:0] idx,
                                              input word_t val, input word_t x, input word_t y,
                                              input word_t z, input word_t w);
    longint acc;
    word_t nxt[16];
    word_t v[4];
    vec4_t res;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    case (op)
      OP_WR_CUR: current_mat[idx] = val;
      OP_WR_STG: staging_mat[idx] = val;
      OP_MUL: begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
              acc += fx_mul(current_mat[k*4+r], staging_mat[c*4+k]);
            end
            nxt[c*4+r] = sat_word(acc);
          end
        end
        current_mat = nxt;
      end
      OP_TRN: begin
        for (int r = 0; r < 4; r++) begin
          acc = longint'(current_mat[12+r]);
          for (int k = 0; k < 3; k++) begin
            acc += fx_mul(current_mat[k*4+r], v[k]);
          end
          res[r] = sat_word(acc);
        end
        for (int r = 0; r < 4; r++) begin
          current_mat[12+r] = res[r];
        end
      end
      OP_XFM: begin
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) begin
            acc += fx_mul(current_mat[k*4+r], v[k]);
          end
          res[r] = sat_word(acc);
        end
        xfm_expected.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [3:0] idx, input word_t val,
                           input word_t x, input word_t y, input word_t z, input word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, w, z, y, x, val, idx};
    do @(posedge clk); while (!in_tready);
    update_matrix_state(op, idx, val, x, y, z, w);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (xfm_expected.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic word_t rand_word();
    int span;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(6))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return 32'sd0;
          3: return 32'sd1;
          4: return -32'sd1;
          5: return FX_ONE;
          default: return -FX_ONE;
        endcase
      end
      1, 2: return word_t'($urandom);
      default: begin
        span = int'($urandom_range(8 * FX_ONE));
        return word_t'(span - 4 * FX_ONE);
      end
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    vec4_t want;
    word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (xfm_expected.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result beat: %h", out_tdata);
        end
        mismatches++;
      end else begin
        want = xfm_expected.pop_front();
        for (int r = 0; r < 4; r++) begin
          got = out_tdata[32*r +: 32];
          if (got !== want[r]) begin
            if (mismatches < 10) begin
              $display("result component %0d: expected %h, actual %h", r, want[r], got);
            end
            mismatches++;
          end
        end
      end
    end
  end

  task automatic test_reset_identity();
    send_beat(OP_XFM, 4'd0, 32'sd0, FX_ONE, 2 * FX_ONE, -3 * FX_ONE, FX_ONE);
    send_beat(OP_XFM, 4'd0, 32'sd0, WORD_MAX, WORD_MIN, -32'sd1, 32'sd0);
  endtask

  task automatic test_saturation();
    send_beat(OP_WR_CUR, 4'd0, WORD_MAX, 0, 0, 0, 0);
    send_beat(OP_WR_CUR, 4'd4, WORD_MAX, 0, 0, 0, 0);
    send_beat(OP_WR_CUR, 4'd1, WORD_MIN, 0, 0, 0, 0);
    send_beat(OP_XFM, 4'd0, 32'sd0, WORD_MAX, WORD_MAX, 32'sd0, 32'sd0);
    send_beat(OP_WR_CUR, 4'd15, -32'sd1, 0, 0, 0, 0);
    send_beat(OP_XFM, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, WORD_MIN);
  endtask

  task automatic test_floor_rounding();
    send_beat(OP_WR_CUR, 4'd10, FX_ONE / 2, 0, 0, 0, 0);
    send_beat(OP_XFM, 4'd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0);
  endtask

  task automatic test_multiply();
    word_t val;
    for (int i = 0; i < 16; i++) begin
      val = (i % 5 == 0) ? 2 * FX_ONE : word_t'((i - 8) * (FX_ONE / 8));
      send_beat(OP_WR_STG, 4'(i), val, 0, 0, 0, 0);
    end
    send_beat(OP_MUL, 4'd0, 32'sd0, 0, 0, 0, 0);
    send_beat(OP_XFM, 4'd0, 32'sd0, FX_ONE, FX_ONE, FX_ONE, FX_ONE);
  endtask

  task automatic test_translate();
    send_beat(OP_TRN, 4'd0, 32'sd0, FX_ONE + FX_ONE / 2, -2 * FX_ONE, WORD_MAX, 32'sd0);
    send_beat(OP_XFM, 4'd0, 32'sd0, FX_ONE, -FX_ONE, FX_ONE / 4, FX_ONE);
  endtask

  task automatic test_ignored_opcodes();
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
      send_beat(3'(op), 4'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
                rand_word());
    end
    send_beat(OP_XFM, 4'd0, 32'sd0, FX_ONE, 2 * FX_ONE, 3 * FX_ONE, FX_ONE);
  endtask

  task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int pick;
    logic [2:0] op;
    word_t z;
    word_t w;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      z = rand_word();
      w = rand_word();
      if (pick < 20) op = OP_WR_CUR;
      else if (pick < 40) op = OP_WR_STG;
      else if (pick < 48) op = OP_MUL;
      else if (pick < 60) op = OP_TRN;
      else if (pick < 95) op = OP_XFM;
      else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (op == OP_XFM && $urandom_range(2) == 0) begin
        z = FX_ONE;
        w = $urandom_range(1) ? FX_ONE : 32'sd0;
      end
      send_beat(op, 4'($urandom), rand_word(), rand_word(), rand_word(), z, w);
      if (op <= OP_XFM) sent++;
    end
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      current_mat[i] = (i % 5 == 0) ? FX_ONE : 32'sd0;
      staging_mat[i] = 32'sd0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_identity();
    test_saturation();
    test_floor_rounding();
    test_multiply();
    test_translate();
    test_ignored_opcodes();
    drain_results();

    test_random(175, 0, 0);
    test_random(175, 45, 0);
    test_random(175, 0, 45);
    test_random(175, 29, 29);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
